>>> sv/fmm_pkg.sv
// ----------------------------------------------------------------------------
// Flight mode manager package
// Shared widths, mode codes, register map, reset values and command scaling
// constants of the flight mode manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmm_pkg;

  // Field widths.
  localparam int AIR_W   = 16;
  localparam int ALT_W   = 18;
  localparam int MODE_W  = 2;
  localparam int CMD_W   = 16;
  localparam int CNT_W   = 8;
  localparam int LIM_W   = 15;

  // Stream payload widths (fields packed from bit 0, padded to bytes).
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // Configuration bus.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Mode codes.
  localparam logic [MODE_W-1:0] FM_OFF      = 2'd0;
  localparam logic [MODE_W-1:0] FM_NORMAL   = 2'd1;
  localparam logic [MODE_W-1:0] FM_DEGRADED = 2'd2;
  localparam logic [MODE_W-1:0] FM_FAILSAFE = 2'd3;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_AIR_LO   = 3'd0;
  localparam logic [2:0] REG_AIR_HI   = 3'd1;
  localparam logic [2:0] REG_ALT_LO   = 3'd2;
  localparam logic [2:0] REG_ALT_HI   = 3'd3;
  localparam logic [2:0] REG_OVS_SET  = 3'd4;
  localparam logic [2:0] REG_OVS_CLR  = 3'd5;
  localparam logic [2:0] REG_PERSIST  = 3'd6;
  localparam logic [2:0] REG_OVS_LIM  = 3'd7;

  // Register reset values.
  localparam logic signed [AIR_W-1:0] RST_AIR_LO  = 16'sd0;
  localparam logic signed [AIR_W-1:0] RST_AIR_HI  = 16'sd4000;
  localparam logic signed [ALT_W-1:0] RST_ALT_LO  = -18'sd100;
  localparam logic signed [ALT_W-1:0] RST_ALT_HI  = 18'sd50000;
  localparam logic signed [AIR_W-1:0] RST_OVS_SET = 16'sd3200;
  localparam logic signed [AIR_W-1:0] RST_OVS_CLR = 16'sd3120;
  localparam logic [CNT_W-1:0]        RST_PERSIST = 8'd50;
  localparam logic [LIM_W-1:0]        RST_OVS_LIM = 15'd3277;

  // Command scaling: |alt| * 16384 / 50000 = |alt| * 1024 / 3125.
  // The reciprocal ceil(2^42 / 3125) gives the exact floor for |alt| < 2^18.
  localparam int                RECIP_W     = 31;
  localparam int                RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_MULT = 31'd1407374884;
  localparam int                QUOT_W      = 17;
  localparam int                MAG_W       = 15;
  localparam logic [MAG_W-1:0]  CMD_FULL    = 15'd16384;

endpackage : fmm_pkg

`default_nettype wire

>>> sv/flight_mode_manager_unit.sv
// ----------------------------------------------------------------------------
// Flight mode manager
// Sensor range check, overspeed hysteresis, OFF/NORMAL/DEGRADED/FAILSAFE
// mode machine and normalized command generation, one frame per transfer.
// ----------------------------------------------------------------------------
// The block takes one sensor frame per clock cycle on the in_ stream while
// the out_ consumer keeps up, and returns exactly one result per frame on the
// out_ stream, in order. A frame is captured in an input register, and the
// whole update (range checks, overspeed hysteresis, mode step and command
// scaling) is a single combinational pass from that register into the output
// register, so the sustained rate is one frame per cycle; the only limit is
// the out_ consumer, and while a result waits one further frame can still
// enter the input register. Disengage has priority: it forces mode OFF and
// clears the overspeed flag and the persistence counter. FAILSAFE is left
// only by disengage. The command is altitude * 16384 / 50000 truncated
// toward zero and clamped to +-16384, halved in DEGRADED, limited to the
// overspeed limit while overspeed is set, and zero in FAILSAFE. The eight
// configuration registers sit at byte addresses 0, 4, ... 28 of the APB-style
// port and must only be written while no frame is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flight_mode_manager_unit
  import fmm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input frame stream.
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // [15:0] airspeed, [33:16] altitude, [34] engage, [35] disengage, [39:36] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream.
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // [1:0] mode, [17:2] command, [18] sensor_bad, [19] overspeed_flag, [23:20] zero
  output      logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output      logic [CFG_DATA_W-1:0] cfg_prdata,
  output      logic                  cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [AIR_W-1:0] air_lo_r;
  logic signed [AIR_W-1:0] air_hi_r;
  logic signed [ALT_W-1:0] alt_lo_r;
  logic signed [ALT_W-1:0] alt_hi_r;
  logic signed [AIR_W-1:0] ovs_set_r;
  logic signed [AIR_W-1:0] ovs_clr_r;
  logic [CNT_W-1:0]        persist_r;
  logic [LIM_W-1:0]        ovs_lim_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  // Only word addresses are decoded; the byte offset bits are ignored.
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      air_lo_r  <= RST_AIR_LO;
      air_hi_r  <= RST_AIR_HI;
      alt_lo_r  <= RST_ALT_LO;
      alt_hi_r  <= RST_ALT_HI;
      ovs_set_r <= RST_OVS_SET;
      ovs_clr_r <= RST_OVS_CLR;
      persist_r <= RST_PERSIST;
      ovs_lim_r <= RST_OVS_LIM;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AIR_LO:  air_lo_r  <= cfg_pwdata[AIR_W-1:0];
        REG_AIR_HI:  air_hi_r  <= cfg_pwdata[AIR_W-1:0];
        REG_ALT_LO:  alt_lo_r  <= cfg_pwdata[ALT_W-1:0];
        REG_ALT_HI:  alt_hi_r  <= cfg_pwdata[ALT_W-1:0];
        REG_OVS_SET: ovs_set_r <= cfg_pwdata[AIR_W-1:0];
        REG_OVS_CLR: ovs_clr_r <= cfg_pwdata[AIR_W-1:0];
        REG_PERSIST: persist_r <= cfg_pwdata[CNT_W-1:0];
        REG_OVS_LIM: ovs_lim_r <= cfg_pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the raw register bits, zero extended.
  always_comb begin
    unique case (cfg_idx)
      REG_AIR_LO:  cfg_prdata = {{(CFG_DATA_W-AIR_W){1'b0}}, air_lo_r};
      REG_AIR_HI:  cfg_prdata = {{(CFG_DATA_W-AIR_W){1'b0}}, air_hi_r};
      REG_ALT_LO:  cfg_prdata = {{(CFG_DATA_W-ALT_W){1'b0}}, alt_lo_r};
      REG_ALT_HI:  cfg_prdata = {{(CFG_DATA_W-ALT_W){1'b0}}, alt_hi_r};
      REG_OVS_SET: cfg_prdata = {{(CFG_DATA_W-AIR_W){1'b0}}, ovs_set_r};
      REG_OVS_CLR: cfg_prdata = {{(CFG_DATA_W-AIR_W){1'b0}}, ovs_clr_r};
      REG_PERSIST: cfg_prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, persist_r};
      REG_OVS_LIM: cfg_prdata = {{(CFG_DATA_W-LIM_W){1'b0}}, ovs_lim_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: input register feeding the output register.
  // The frame in the input register moves on whenever the output register is
  // empty or its result is taken in the same cycle.
  // --------------------------------------------------------------------------
  logic in_valid_r;
  logic out_valid_r;
  logic advance;

  assign advance    = ~out_valid_r | out_tready;
  assign in_tready  = ~in_valid_r | advance;
  assign out_tvalid = out_valid_r;

  logic signed [AIR_W-1:0] air_r;
  logic signed [ALT_W-1:0] alt_r;
  logic                    engage_r;
  logic                    disengage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      air_r       <= in_tdata[15:0];
      alt_r       <= in_tdata[33:16];
      engage_r    <= in_tdata[34];
      disengage_r <= in_tdata[35];
    end
  end

  // --------------------------------------------------------------------------
  // Frame state and its update
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              ovs_r, ovs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              bad_nxt;
  logic [CNT_W-1:0]  cnt_inc;
  logic              air_ok;
  logic              alt_ok;
  logic              step;

  assign step    = in_valid_r & advance;
  assign air_ok  = (air_r >= air_lo_r) && (air_r <= air_hi_r);
  assign alt_ok  = (alt_r >= alt_lo_r) && (alt_r <= alt_hi_r);
  // The count is only incremented while below persist_r, so it cannot wrap.
  assign cnt_inc = (cnt_r < persist_r) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    mode_nxt = mode_r;
    ovs_nxt  = ovs_r;
    cnt_nxt  = cnt_r;
    bad_nxt  = 1'b0;
    if (disengage_r) begin
      mode_nxt = FM_OFF;
      ovs_nxt  = 1'b0;
      cnt_nxt  = '0;
    end else begin
      bad_nxt = ~(air_ok & alt_ok);
      // Overspeed sets at or above the set level and clears below the clear
      // level, which gives the hysteresis band in between.
      if (!ovs_r) begin
        ovs_nxt = (air_r >= ovs_set_r);
      end else begin
        ovs_nxt = ~(air_r < ovs_clr_r);
      end
      unique case (mode_r)
        FM_OFF: begin
          cnt_nxt = '0;
          if (engage_r && !bad_nxt) begin
            mode_nxt = FM_NORMAL;
          end
        end
        FM_NORMAL: begin
          if (bad_nxt) begin
            mode_nxt = FM_DEGRADED;
            cnt_nxt  = {{(CNT_W-1){1'b0}}, 1'b1};
          end else begin
            cnt_nxt = '0;
          end
        end
        FM_DEGRADED: begin
          if (bad_nxt) begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= persist_r) begin
              mode_nxt = FM_FAILSAFE;
            end
          end else begin
            mode_nxt = FM_NORMAL;
            cnt_nxt  = '0;
          end
        end
        FM_FAILSAFE: begin
          mode_nxt = FM_FAILSAFE;
        end
        default: begin
          mode_nxt = FM_FAILSAFE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= FM_OFF;
      ovs_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      ovs_r  <= ovs_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Command. Everything is done on the magnitude of the altitude and the sign
  // is put back at the end, which makes every rounding step truncate toward
  // zero. The reciprocal product gives the exact quotient by 3125.
  // --------------------------------------------------------------------------
  logic                            alt_neg;
  logic [ALT_W-1:0]                alt_abs;
  logic [ALT_W+RECIP_W-1:0]        prod;
  logic [QUOT_W-1:0]               quot;
  logic [MAG_W-1:0]                mag_full;
  logic [MAG_W-1:0]                mag_mode;
  logic [MAG_W-1:0]                mag_lim;
  logic signed [CMD_W-1:0]         cmd_nxt;

  assign alt_neg  = alt_r[ALT_W-1];
  assign alt_abs  = alt_neg ? (~alt_r + 1'b1) : alt_r;
  assign prod     = alt_abs * RECIP_MULT;
  assign quot     = prod[RECIP_SHIFT +: QUOT_W];
  assign mag_full = (quot > {{(QUOT_W-MAG_W){1'b0}}, CMD_FULL}) ? CMD_FULL
                                                                 : quot[MAG_W-1:0];
  assign mag_mode = (mode_nxt == FM_DEGRADED) ? (mag_full >> 1) : mag_full;
  assign mag_lim  = (ovs_nxt && (mag_mode > ovs_lim_r)) ? ovs_lim_r : mag_mode;

  always_comb begin
    if (mode_nxt == FM_FAILSAFE) begin
      cmd_nxt = '0;
    end else if (alt_neg) begin
      cmd_nxt = -$signed({1'b0, mag_lim});
    end else begin
      cmd_nxt = $signed({1'b0, mag_lim});
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0]       out_mode_r;
  logic signed [CMD_W-1:0] out_cmd_r;
  logic                    out_bad_r;
  logic                    out_ovs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_mode_r <= mode_nxt;
      out_cmd_r  <= cmd_nxt;
      out_bad_r  <= bad_nxt;
      out_ovs_r  <= ovs_nxt;
    end
  end

  assign out_tdata = {4'b0000, out_ovs_r, out_bad_r, out_cmd_r, out_mode_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // FAILSAFE is only ever left through a disengage frame.
  a_failsafe_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (step && mode_r == FM_FAILSAFE && !disengage_r) |=> mode_r == FM_FAILSAFE)
    else $error("failsafe left without disengage");

  // A FAILSAFE result always carries a zero command.
  a_failsafe_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r == FM_FAILSAFE) |-> out_cmd_r == '0)
    else $error("nonzero command in failsafe");

  // The command never leaves full scale.
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cmd_r <= 16'sd16384 && out_cmd_r >= -16'sd16384))
    else $error("command beyond full scale");

  // The persistence counter is clear whenever the mode is OFF.
  a_off_count: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == FM_OFF |-> cnt_r == '0)
    else $error("persistence count set in off");

endmodule : flight_mode_manager_unit

`default_nettype wire

>>> dv/tb_flight_mode_manager_unit.sv
// ----------------------------------------------------------------------------
// Flight mode manager testbench
// Drives sensor frames into the flight mode manager over the in_ stream and
// checks every out_ transfer against an in-bench prediction of the mode
// machine, overspeed hysteresis and command scaling. A directed table comes
// first, then randomized frame sequences under several register settings,
// with random stalls on both streams under all but the last two settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_flight_mode_manager_unit;
  import fmm_pkg::*;

  localparam int     CLK_HALF      = 4;
  localparam int     RESET_CYCLES  = 5;
  localparam int     RANDOM_FRAMES = 1250;
  localparam int     CONFIG_SETS   = 6;
  localparam int     IDLE_CYCLES   = 4;
  localparam int     DRAIN_CYCLES  = 8;
  localparam int     MAX_REPORTS   = 40;
  localparam longint CYCLE_LIMIT   = 200000;

  // Full-scale command and the altitude that maps to it.
  localparam longint FULL_SCALE = 16384;
  localparam longint ALT_SPAN   = 50000;

  localparam longint AIR_MIN = -32768;
  localparam longint AIR_MAX = 32767;
  localparam longint ALT_MIN = -131072;
  localparam longint ALT_MAX = 131071;

  typedef struct packed {
    logic signed [AIR_W-1:0] airspeed;
    logic signed [ALT_W-1:0] altitude;
    logic                    engage;
    logic                    disengage;
  } sensor_frame_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [CMD_W-1:0] command;
    logic                    sensor_bad;
    logic                    overspeed;
  } mode_result_t;

  typedef enum logic { ROW_FRAME, ROW_WRITE } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    sensor_frame_t         frame;
    bit                    fixed;
    mode_result_t          result;
    logic [2:0]            reg_idx;
    logic [CFG_DATA_W-1:0] reg_value;
  } stim_row_t;

  // DUT connections; every input has a known value from time zero.
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Predicted register contents, starting from their reset values.
  logic signed [AIR_W-1:0] fm_air_lo  = RST_AIR_LO;
  logic signed [AIR_W-1:0] fm_air_hi  = RST_AIR_HI;
  logic signed [ALT_W-1:0] fm_alt_lo  = RST_ALT_LO;
  logic signed [ALT_W-1:0] fm_alt_hi  = RST_ALT_HI;
  logic signed [AIR_W-1:0] fm_ovs_set = RST_OVS_SET;
  logic signed [AIR_W-1:0] fm_ovs_clr = RST_OVS_CLR;
  logic [CNT_W-1:0]        fm_persist = RST_PERSIST;
  logic [LIM_W-1:0]        fm_ovs_lim = RST_OVS_LIM;

  // Predicted block state.
  logic [MODE_W-1:0] fm_mode  = FM_OFF;
  logic              fm_bad   = 1'b0;
  logic              fm_ovs   = 1'b0;
  logic [CNT_W-1:0]  fm_count = '0;

  mode_result_t pending_results[$];
  int           error_count   = 0;
  int           send_idle_pct = 28;
  int           recv_idle_pct = 45;
  int           burst_left    = 0;
  longint       cycle_count   = 0;

  flight_mode_manager_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic longint clamp(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Uniform value between two bounds, in either order.
  function automatic longint pick_range(longint a, longint b);
    longint lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return lo + longint'($urandom_range(hi - lo));
  endfunction

  function automatic longint near(longint center);
    return clamp(center + int'($urandom_range(16)) - 8, AIR_MIN, AIR_MAX);
  endfunction

  // A value a little outside [lo, hi]; falls back to anything when the range
  // already covers the whole field.
  function automatic longint just_outside(longint lo, longint hi, longint fmin,
                                          longint fmax);
    if (hi < fmax && (lo <= fmin || $urandom_range(1) == 1))
      return pick_range(hi + 1, clamp(hi + 16, fmin, fmax));
    if (lo > fmin)
      return pick_range(clamp(lo - 16, fmin, fmax), lo - 1);
    return pick_range(fmin, fmax);
  endfunction

  // Steps the predicted state by one accepted frame and returns the result
  // that the block must produce for it.
  function automatic mode_result_t advance_flight_state(sensor_frame_t f);
    logic signed [AIR_W-1:0] air;
    logic signed [ALT_W-1:0] alt;
    longint                  cmd;
    longint                  lim;
    mode_result_t            r;
    air = f.airspeed;
    alt = f.altitude;
    if (f.disengage) begin
      fm_mode  = FM_OFF;
      fm_bad   = 1'b0;
      fm_ovs   = 1'b0;
      fm_count = '0;
    end else begin
      fm_bad = !(air >= fm_air_lo && air <= fm_air_hi &&
                 alt >= fm_alt_lo && alt <= fm_alt_hi);
      // Hysteresis: set at or above the set level, clear below the clear level.
      if (!fm_ovs)
        fm_ovs = (air >= fm_ovs_set);
      else if (air < fm_ovs_clr)
        fm_ovs = 1'b0;
      case (fm_mode)
        FM_OFF: begin
          fm_count = '0;
          if (f.engage && !fm_bad)
            fm_mode = FM_NORMAL;
        end
        FM_NORMAL: begin
          if (fm_bad) begin
            fm_mode  = FM_DEGRADED;
            fm_count = 1;
          end else begin
            fm_count = '0;
          end
        end
        FM_DEGRADED: begin
          if (fm_bad) begin
            if (fm_count < fm_persist)
              fm_count = fm_count + 1;
            if (fm_count >= fm_persist)
              fm_mode = FM_FAILSAFE;
          end else begin
            fm_mode  = FM_NORMAL;
            fm_count = '0;
          end
        end
        default: fm_mode = FM_FAILSAFE;
      endcase
    end

    // The command follows the new mode and the new overspeed flag.
    if (fm_mode == FM_FAILSAFE) begin
      cmd = 0;
    end else begin
      cmd = clamp((longint'(alt) * FULL_SCALE) / ALT_SPAN, -FULL_SCALE, FULL_SCALE);
      if (fm_mode == FM_DEGRADED)
        cmd = cmd / 2;
      lim = fm_ovs ? longint'(fm_ovs_lim) : FULL_SCALE;
      cmd = clamp(cmd, -lim, lim);
    end
    r.mode       = fm_mode;
    r.command    = cmd[CMD_W-1:0];
    r.sensor_bad = fm_bad;
    r.overspeed  = fm_ovs;
    return r;
  endfunction

  // Random frame. Most frames are in range, many with airspeed near the
  // overspeed levels; bursts of out-of-range frames drive the machine through
  // DEGRADED into FAILSAFE, and disengage is frequent in FAILSAFE to leave it.
  function automatic sensor_frame_t random_frame();
    sensor_frame_t f;
    int unsigned   pick;
    bit            broken;
    if (burst_left == 0 && $urandom_range(19) == 0)
      burst_left = $urandom_range(int'(fm_persist) + 2, 1);
    broken = (burst_left != 0);
    if (broken)
      burst_left--;
    pick = $urandom_range(99);
    if (pick < 10) begin
      f.airspeed = $urandom;
      f.altitude = $urandom;
    end else begin
      if (pick < 30)
        f.airspeed = near(fm_ovs_set);
      else if (pick < 45)
        f.airspeed = near(fm_ovs_clr);
      else
        f.airspeed = pick_range(fm_air_lo, fm_air_hi);
      f.altitude = pick_range(fm_alt_lo, fm_alt_hi);
      if (broken) begin
        if ($urandom_range(1) == 1)
          f.airspeed = just_outside(fm_air_lo, fm_air_hi, AIR_MIN, AIR_MAX);
        else
          f.altitude = just_outside(fm_alt_lo, fm_alt_hi, ALT_MIN, ALT_MAX);
      end
    end
    f.engage    = $urandom_range(1);
    f.disengage = (fm_mode == FM_FAILSAFE) ? ($urandom_range(3) == 0)
                                           : ($urandom_range(39) == 0);
    return f;
  endfunction

  function automatic stim_row_t frame_row(int air, int alt, bit eng, bit dis);
    stim_row_t r;
    r.kind               = ROW_FRAME;
    r.frame.airspeed     = air;
    r.frame.altitude     = alt;
    r.frame.engage       = eng;
    r.frame.disengage    = dis;
    r.fixed              = 1'b0;
    r.result             = '0;
    r.reg_idx            = '0;
    r.reg_value          = '0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(int air, int alt, bit eng, bit dis,
                                            logic [MODE_W-1:0] mode, int cmd,
                                            bit bad, bit ovs);
    stim_row_t r;
    r                   = frame_row(air, alt, eng, dis);
    r.fixed             = 1'b1;
    r.result.mode       = mode;
    r.result.command    = cmd;
    r.result.sensor_bad = bad;
    r.result.overspeed  = ovs;
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [2:0] idx, int value);
    stim_row_t r;
    r           = frame_row(0, 0, 1'b0, 1'b0);
    r.kind      = ROW_WRITE;
    r.reg_idx   = idx;
    r.reg_value = value;
    return r;
  endfunction

  // Holds the input stream idle until every expected result has come back.
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Register write over the APB-style port, only once the block is idle. The
  // unused upper data bits carry random junk that the block must drop.
  task automatic write_register(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
    int                    width;
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] junk;
    wait_until_drained();
    repeat (IDLE_CYCLES) @(posedge clk);
    case (idx)
      REG_ALT_LO, REG_ALT_HI: width = ALT_W;
      REG_PERSIST:            width = CNT_W;
      REG_OVS_LIM:            width = LIM_W;
      default:                width = AIR_W;
    endcase
    mask = (32'h1 << width) - 1;
    junk = $urandom;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= (value & mask) | (junk & ~mask);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_AIR_LO:  fm_air_lo  = value[AIR_W-1:0];
      REG_AIR_HI:  fm_air_hi  = value[AIR_W-1:0];
      REG_ALT_LO:  fm_alt_lo  = value[ALT_W-1:0];
      REG_ALT_HI:  fm_alt_hi  = value[ALT_W-1:0];
      REG_OVS_SET: fm_ovs_set = value[AIR_W-1:0];
      REG_OVS_CLR: fm_ovs_clr = value[AIR_W-1:0];
      REG_PERSIST: fm_persist = value[CNT_W-1:0];
      default:     fm_ovs_lim = value[LIM_W-1:0];
    endcase
    @(posedge clk);
  endtask

  // Offers one frame with a random lead-in gap and, once the transfer has
  // happened, queues the result it must cause. A typed-in expectation takes
  // the place of the predicted one, but the prediction still advances.
  task automatic send_frame(sensor_frame_t f, bit fixed, mode_result_t fixed_result);
    mode_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({f.disengage, f.engage, f.altitude, f.airspeed});
    do @(posedge clk); while (!in_tready);
    r = advance_flight_state(f);
    pending_results.push_back(fixed ? fixed_result : r);
  endtask

  // Writes all eight registers for one random phase.
  task automatic apply_config_set(int set_idx);
    longint air_lo, air_hi, alt_lo, alt_hi, set_lvl;
    case (set_idx)
      0: begin
        // Reset values, written back explicitly after the directed part.
        write_register(REG_AIR_LO,  RST_AIR_LO);
        write_register(REG_AIR_HI,  RST_AIR_HI);
        write_register(REG_ALT_LO,  RST_ALT_LO);
        write_register(REG_ALT_HI,  RST_ALT_HI);
        write_register(REG_OVS_SET, RST_OVS_SET);
        write_register(REG_OVS_CLR, RST_OVS_CLR);
        write_register(REG_PERSIST, RST_PERSIST);
        write_register(REG_OVS_LIM, RST_OVS_LIM);
      end
      1: begin
        // Widest ranges, overspeed hard to set and never cleared, longest
        // persistence and a zero command limit under overspeed.
        write_register(REG_AIR_LO,  AIR_MIN);
        write_register(REG_AIR_HI,  AIR_MAX);
        write_register(REG_ALT_LO,  ALT_MIN);
        write_register(REG_ALT_HI,  ALT_MAX);
        write_register(REG_OVS_SET, AIR_MAX);
        write_register(REG_OVS_CLR, AIR_MIN);
        write_register(REG_PERSIST, 255);
        write_register(REG_OVS_LIM, 0);
      end
      2: begin
        // Overspeed sets on the first frame without disengage; only disengage clears it.
        write_register(REG_AIR_LO,  500);
        write_register(REG_AIR_HI,  3500);
        write_register(REG_ALT_LO,  -100);
        write_register(REG_ALT_HI,  50000);
        write_register(REG_OVS_SET, AIR_MIN);
        write_register(REG_OVS_CLR, AIR_MIN);
        write_register(REG_PERSIST, 1);
        write_register(REG_OVS_LIM, FULL_SCALE);
      end
      default: begin
        // Random ranges; a negative span now and then inverts a range.
        air_lo  = pick_range(-500, 1500);
        air_hi  = clamp(air_lo + pick_range(-100, 5000), AIR_MIN, AIR_MAX);
        alt_lo  = pick_range(-2000, 2000);
        alt_hi  = clamp(alt_lo + pick_range(-500, 100000), ALT_MIN, ALT_MAX);
        set_lvl = pick_range(air_lo, air_hi);
        write_register(REG_AIR_LO,  air_lo);
        write_register(REG_AIR_HI,  air_hi);
        write_register(REG_ALT_LO,  alt_lo);
        write_register(REG_ALT_HI,  alt_hi);
        write_register(REG_OVS_SET, set_lvl);
        write_register(REG_OVS_CLR, clamp(set_lvl - pick_range(0, 300), AIR_MIN, AIR_MAX));
        write_register(REG_PERSIST, (set_idx == 4) ? $urandom_range(255, 20)
                                                   : $urandom_range(8));
        write_register(REG_OVS_LIM, $urandom_range(32767));
      end
    endcase
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result side: random back-pressure and an in-order check of each transfer
  // against the oldest pending expectation.
  always @(posedge clk) begin
    mode_result_t got;
    mode_result_t want;
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got.mode       = out_tdata[1:0];
      got.command    = out_tdata[17:2];
      got.sensor_bad = out_tdata[18];
      got.overspeed  = out_tdata[19];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("mode", want.mode, got.mode);
        check_field("command", longint'(want.command), longint'(got.command));
        check_field("sensor_bad", want.sensor_bad, got.sensor_bad);
        check_field("overspeed_flag", want.overspeed, got.overspeed);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_flight_mode_manager_unit: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t directed_rows[$];
    int        per_set;
    int        frames_left;

    // Reset state first, then the field extremes under the reset settings.
    directed_rows.push_back(checked_row(1000, 0, 1'b0, 1'b0, FM_OFF, 0, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(1000, 50000, 1'b0, 1'b0, FM_OFF, 16384, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(-32768, -131072, 1'b1, 1'b0,
                                        FM_OFF, -16384, 1'b1, 1'b0));
    directed_rows.push_back(checked_row(32767, 131071, 1'b1, 1'b0,
                                        FM_OFF, 3277, 1'b1, 1'b1));
    // Engage while overspeed is held by hysteresis, then let it clear.
    directed_rows.push_back(frame_row(3150, 1000, 1'b1, 1'b0));
    directed_rows.push_back(frame_row(3100, -50000, 1'b0, 1'b0));
    // DEGRADED with halving and the overspeed limit, and back.
    directed_rows.push_back(frame_row(5000, 20000, 1'b0, 1'b0));
    directed_rows.push_back(frame_row(1000, -20000, 1'b1, 1'b0));
    // Negative halving and truncation must both go toward zero.
    directed_rows.push_back(frame_row(1000, -101, 1'b0, 1'b0));
    directed_rows.push_back(frame_row(1000, -1, 1'b0, 1'b0));
    directed_rows.push_back(frame_row(1000, 50001, 1'b0, 1'b0));
    directed_rows.push_back(frame_row(-1, 50000, 1'b0, 1'b0));
    // Persistence lowered below the running count: next bad frame is FAILSAFE.
    directed_rows.push_back(write_row(REG_PERSIST, 1));
    directed_rows.push_back(checked_row(-1, 0, 1'b0, 1'b0, FM_FAILSAFE, 0, 1'b1, 1'b0));
    directed_rows.push_back(checked_row(1000, 100, 1'b1, 1'b0, FM_FAILSAFE, 0, 1'b0, 1'b0));
    // Engage and disengage together: disengage wins.
    directed_rows.push_back(checked_row(0, 0, 1'b1, 1'b1, FM_OFF, 0, 1'b0, 1'b0));
    // Zero persistence: the first bad frame seen in DEGRADED enters FAILSAFE.
    directed_rows.push_back(write_row(REG_PERSIST, 0));
    directed_rows.push_back(frame_row(100, 100, 1'b1, 1'b0));
    directed_rows.push_back(frame_row(100, -131072, 1'b0, 1'b0));
    directed_rows.push_back(frame_row(100, -131072, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(0, 0, 1'b0, 1'b1, FM_OFF, 0, 1'b0, 1'b0));
    // An overspeed limit above full scale changes nothing beyond the clamp.
    directed_rows.push_back(write_row(REG_OVS_LIM, 32767));
    directed_rows.push_back(checked_row(32767, 131071, 1'b0, 1'b0,
                                        FM_OFF, 16384, 1'b1, 1'b1));
    // Inverted altitude limits make every frame invalid.
    directed_rows.push_back(write_row(REG_ALT_LO, 10));
    directed_rows.push_back(write_row(REG_ALT_HI, -10));
    directed_rows.push_back(frame_row(1000, 0, 1'b1, 1'b0));
    directed_rows.push_back(frame_row(3119, 5, 1'b1, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      else
        send_frame(directed_rows[i].frame, directed_rows[i].fixed, directed_rows[i].result);
    end

    // Random part: two register settings per idling pattern. The first
    // pattern stalls the sender less than the receiver, the second the other
    // way round, the last runs both streams flat out.
    frames_left = RANDOM_FRAMES;
    for (int s = 0; s < CONFIG_SETS; s++) begin
      case (s / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      apply_config_set(s);
      per_set = (s == CONFIG_SETS - 1) ? frames_left : RANDOM_FRAMES / CONFIG_SETS;
      frames_left -= per_set;
      for (int n = 0; n < per_set; n++) begin
        // Now and then the sender waits for the block to empty completely.
        if (n % 150 == 75)
          wait_until_drained();
        send_frame(random_frame(), 1'b0, '0);
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_flight_mode_manager_unit: clean");
    else
      $display("tb_flight_mode_manager_unit: errors");
    $finish;
  end

endmodule

>>> files.f
sv/fmm_pkg.sv
sv/flight_mode_manager_unit.sv
dv/tb_flight_mode_manager_unit.sv
